### src/atan2_polynomial_approx_defines.svh
// ----------------------------------------------------------------------------
// atan2 approximation: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ATAN2_POLYNOMIAL_APPROX_DEFINES_SVH
`define ATAN2_POLYNOMIAL_APPROX_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATAN2PA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("atan2 approximation: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ATAN2PA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("atan2 approximation: next-cycle check failed");

`endif

### src/atan2pa_pkg.sv
// ----------------------------------------------------------------------------
// atan2 approximation package
// Formats, polynomial coefficients, angle constants and payload types.
// ----------------------------------------------------------------------------
package atan2pa_pkg;

	localparam int IN_WIDTH        = 16;
	localparam int ANGLE_FRAC_BITS = 13;
	localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 3;
	localparam int ANGLE_SHIFT     = 30 - ANGLE_FRAC_BITS;

	// Ratio z is Q0.16, produced DIV_STEP_BITS quotient bits per divider stage.
	localparam int RATIO_BITS    = 16;
	localparam int DIV_STEP_BITS = 4;

	// Polynomial coefficients in Q2.30.
	localparam logic signed [31:0] COEF_A1 = 32'sd1073597943;
	localparam logic signed [31:0] COEF_A3 = -32'sd354656388;
	localparam logic signed [31:0] COEF_A5 = 32'sd193424926;
	localparam logic signed [31:0] COEF_A7 = -32'sd91410863;
	localparam logic signed [31:0] COEF_A9 = 32'sd22371518;

	// Angles in Q2.30; bit 33 stays clear so they can be used as signed.
	localparam logic [33:0] Q30_PI      = 34'd3373259426;
	localparam logic [33:0] Q30_HALF_PI = 34'd1686629713;

	localparam logic [32:0] ROUND_HALF = 33'(1) << (ANGLE_SHIFT - 1);
	localparam logic [32:0] PI_CODE    = 33'((Q30_PI + 34'(ROUND_HALF)) >> ANGLE_SHIFT);

	typedef struct packed {
		logic signed [IN_WIDTH-1:0] x_coord;
		logic signed [IN_WIDTH-1:0] y_coord;
	} sample_t;

	typedef struct packed {
		logic signed [ANGLE_WIDTH-1:0] angle;
		logic                          zero_input;
	} result_t;

	// Octant and quadrant information that rides along with the ratio.
	typedef struct packed {
		logic zero;
		logic invert;
		logic x_neg;
		logic y_neg;
	} side_t;

endpackage

### src/atan2pa_ratio_div.sv
// ----------------------------------------------------------------------------
// atan2 approximation: pipelined ratio divider
// Restoring division min/max into a Q0.16 ratio, STEP_BITS bits per stage.
// ----------------------------------------------------------------------------
`include "atan2_polynomial_approx_defines.svh"

module atan2pa_ratio_div #(
	parameter int STEP_BITS = atan2pa_pkg::DIV_STEP_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               up_valid,
	output logic                               up_ready,
	input  logic [atan2pa_pkg::IN_WIDTH-1:0]   mn,
	input  logic [atan2pa_pkg::IN_WIDTH-1:0]   mx,
	input  atan2pa_pkg::side_t                 up_side,
	output logic                               dn_valid,
	input  logic                               dn_ready,
	output logic [atan2pa_pkg::RATIO_BITS-1:0] z,
	output atan2pa_pkg::side_t                 dn_side
);

	localparam int W      = atan2pa_pkg::IN_WIDTH;
	localparam int QB     = atan2pa_pkg::RATIO_BITS;
	localparam int STAGES = QB / STEP_BITS;

	typedef struct packed {
		logic [W:0]         rem;
		logic [W-1:0]       den;
		logic [QB-1:0]      quo;
		atan2pa_pkg::side_t side;
	} div_t;

	// The remainder never exceeds the divisor, which is at most 2^(W-1), so the
	// doubled remainder fits in W+1 bits. Equal operands give all ones.
	function automatic div_t div_step(div_t d);
		div_t       r;
		logic [W:0] sh;
		r = d;
		for (int i = 0; i < STEP_BITS; i++) begin
			sh = {r.rem[W-1:0], 1'b0};
			if (sh >= {1'b0, r.den}) begin
				r.rem = sh - {1'b0, r.den};
				r.quo = {r.quo[QB-2:0], 1'b1};
			end else begin
				r.rem = sh;
				r.quo = {r.quo[QB-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	div_t div_s [STAGES];
	div_t src_d [STAGES];
	logic src_v [STAGES];
	logic vld_s [STAGES];
	logic en_s  [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		if (k == 0) begin : g_first
			always_comb begin
				src_d[k].rem  = {1'b0, mn};
				src_d[k].den  = mx;
				src_d[k].quo  = '0;
				src_d[k].side = up_side;
				src_v[k]      = up_valid;
			end
		end else begin : g_next
			assign src_d[k] = div_s[k-1];
			assign src_v[k] = vld_s[k-1];
		end

		if (k == STAGES - 1) begin : g_last_en
			assign en_s[k] = !vld_s[k] || dn_ready;
		end else begin : g_mid_en
			assign en_s[k] = !vld_s[k] || en_s[k+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en_s[k]) begin
				vld_s[k] <= src_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en_s[k]) begin
				div_s[k] <= div_step(src_d[k]);
			end
		end
	end

	assign up_ready = en_s[0];
	assign dn_valid = vld_s[STAGES-1];
	assign z        = div_s[STAGES-1].quo;
	assign dn_side  = div_s[STAGES-1].side;

	`ATAN2PA_ASSERT_IMPL(a_rem_bound, vld_s[STAGES-1],
		div_s[STAGES-1].rem <= {1'b0, div_s[STAGES-1].den})

endmodule

### src/atan2pa_poly.sv
// ----------------------------------------------------------------------------
// atan2 approximation: odd polynomial pipeline
// Evaluates atan(z) in Q2.30 over seven stages, at most one multiply level each.
// ----------------------------------------------------------------------------
`include "atan2_polynomial_approx_defines.svh"

module atan2pa_poly (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               up_valid,
	output logic                               up_ready,
	input  logic [atan2pa_pkg::RATIO_BITS-1:0] z,
	input  atan2pa_pkg::side_t                 up_side,
	output logic                               dn_valid,
	input  logic                               dn_ready,
	output logic signed [31:0]                 th,
	output atan2pa_pkg::side_t                 dn_side
);

	localparam int NS = 7;

	logic [NS-1:0] vld_s;
	logic [NS-1:0] en_s;

	logic [15:0] z_s1, z_s2, z_s3, z_s4, z_s5, z_s6;
	logic [15:0] z2_s1, z2_s2, z2_s3, z2_s4;
	logic [15:0] z4_s2, z4_s3, z4_s4;
	logic signed [31:0] t7_s3, t9_s3;
	logic signed [31:0] u3_s4, u5_s4;
	logic signed [31:0] m3_s5, m5_s5;
	logic signed [31:0] p_s6;
	logic signed [31:0] th_s7;
	atan2pa_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;

	logic [31:0]        zz, z2z2;
	logic signed [48:0] prod7, prod9, prod3, prod5, prodz;

	always_comb begin
		en_s[NS-1] = !vld_s[NS-1] || dn_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en_s[k] = !vld_s[k] || en_s[k+1];
		end
	end

	// Products but the first square are taken from registers; the upper part-selects are floor shifts.
	always_comb begin
		zz    = {16'd0, z} * {16'd0, z};
		z2z2  = {16'd0, z2_s1} * {16'd0, z2_s1};
		prod7 = $signed({1'b0, z4_s2}) * atan2pa_pkg::COEF_A7;
		prod9 = $signed({1'b0, z4_s2}) * atan2pa_pkg::COEF_A9;
		prod3 = $signed({1'b0, z2_s4}) * u3_s4;
		prod5 = $signed({1'b0, z4_s4}) * u5_s4;
		prodz = $signed({1'b0, z_s6}) * p_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en_s[0]) begin
				vld_s[0] <= up_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en_s[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s[0]) begin
			z_s1    <= z;
			z2_s1   <= zz[31:16];
			side_s1 <= up_side;
		end
		if (en_s[1]) begin
			z_s2    <= z_s1;
			z2_s2   <= z2_s1;
			z4_s2   <= z2z2[31:16];
			side_s2 <= side_s1;
		end
		if (en_s[2]) begin
			z_s3    <= z_s2;
			z2_s3   <= z2_s2;
			z4_s3   <= z4_s2;
			t7_s3   <= prod7[47:16];
			t9_s3   <= prod9[47:16];
			side_s3 <= side_s2;
		end
		if (en_s[3]) begin
			z_s4    <= z_s3;
			z2_s4   <= z2_s3;
			z4_s4   <= z4_s3;
			u3_s4   <= atan2pa_pkg::COEF_A3 + t7_s3;
			u5_s4   <= atan2pa_pkg::COEF_A5 + t9_s3;
			side_s4 <= side_s3;
		end
		if (en_s[4]) begin
			z_s5    <= z_s4;
			m3_s5   <= prod3[47:16];
			m5_s5   <= prod5[47:16];
			side_s5 <= side_s4;
		end
		if (en_s[5]) begin
			z_s6    <= z_s5;
			p_s6    <= atan2pa_pkg::COEF_A1 + m3_s5 + m5_s5;
			side_s6 <= side_s5;
		end
		if (en_s[6]) begin
			th_s7   <= prodz[47:16];
			side_s7 <= side_s6;
		end
	end

	assign up_ready = en_s[0];
	assign dn_valid = vld_s[NS-1];
	assign th       = th_s7;
	assign dn_side  = side_s7;

	`ATAN2PA_ASSERT_NEXT(a_hold_last, vld_s[NS-1] && !dn_ready,
		vld_s[NS-1] && $stable(th_s7) && $stable(side_s7))

endmodule

### src/atan2pa_fold.sv
// ----------------------------------------------------------------------------
// atan2 approximation: octant fold and output rounding
// Maps the first-octant angle to the full circle, rounds, saturates, signs.
// ----------------------------------------------------------------------------
`include "atan2_polynomial_approx_defines.svh"

module atan2pa_fold (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  logic signed [31:0]   th,
	input  atan2pa_pkg::side_t   up_side,
	output logic                 dn_valid,
	input  logic                 dn_ready,
	output atan2pa_pkg::result_t result
);

	localparam int AW = atan2pa_pkg::ANGLE_WIDTH;

	logic                 vld_s1, vld_s2;
	logic                 en_s1, en_s2;
	logic [31:0]          mag30_s1;
	atan2pa_pkg::side_t   side_s1;
	atan2pa_pkg::result_t res_s2;

	logic signed [33:0] th1, th2;
	logic [32:0]        rsum, rmag, smag;
	logic [AW-1:0]      mag_o;

	assign en_s2 = !vld_s2 || dn_ready;
	assign en_s1 = !vld_s1 || en_s2;

	always_comb begin
		th1 = up_side.invert ? $signed(atan2pa_pkg::Q30_HALF_PI) - 34'(th) : 34'(th);
		th2 = up_side.x_neg  ? $signed(atan2pa_pkg::Q30_PI) - th1 : th1;
		if (th2 < 0) begin
			th2 = '0;
		end
	end

	// Rounding is done on the magnitude so that the sign of y is symmetric.
	always_comb begin
		rsum  = {1'b0, mag30_s1} + atan2pa_pkg::ROUND_HALF;
		rmag  = rsum >> atan2pa_pkg::ANGLE_SHIFT;
		smag  = (rmag > atan2pa_pkg::PI_CODE) ? atan2pa_pkg::PI_CODE : rmag;
		mag_o = smag[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= up_valid;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mag30_s1 <= th2[31:0];
			side_s1  <= up_side;
		end
		if (en_s2) begin
			if (side_s1.zero) begin
				res_s2.angle      <= '0;
				res_s2.zero_input <= 1'b1;
			end else begin
				res_s2.angle      <= side_s1.y_neg ? $signed(-mag_o) : $signed(mag_o);
				res_s2.zero_input <= 1'b0;
			end
		end
	end

	assign up_ready = en_s1;
	assign dn_valid = vld_s2;
	assign result   = res_s2;

	`ATAN2PA_ASSERT_NEXT(a_zero_result, en_s2 && vld_s1 && side_s1.zero,
		vld_s2 && res_s2.zero_input && (res_s2.angle == '0))

endmodule

### src/atan2_polynomial_approx.sv
// ----------------------------------------------------------------------------
// atan2 polynomial approximation, top level
// Fixed-point atan2(y, x) with a ninth-order odd polynomial, Q2.13 radians.
// ----------------------------------------------------------------------------
//  channel  handshake                    payload
//  sample   sample_valid / sample_stall  sample.x_coord, sample.y_coord
//  result   result_valid / result_stall  result.angle, result.zero_input
//
//  One transaction per cycle is accepted and delivered when no stall is held.
//  Items pass through the magnitude stage and the divider stages, then the
//  polynomial and fold stages.
//  Reset clears only the stage valid bits; no data is held after it.
//  result_stall freezes the output register; bubbles ahead of a stalled item
//  still fill, and sample_stall rises only when every stage holds an item.
// ----------------------------------------------------------------------------
`include "atan2_polynomial_approx_defines.svh"

module atan2_polynomial_approx #(
	parameter int DIV_STEP_BITS = atan2pa_pkg::DIV_STEP_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  atan2pa_pkg::sample_t sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output atan2pa_pkg::result_t result
);

	localparam int W = atan2pa_pkg::IN_WIDTH;

	logic               vld_s1, en_s1;
	logic [W-1:0]       mn_s1, mx_s1;
	atan2pa_pkg::side_t side_s1;

	logic [W-1:0] ax, ay;
	logic         inv;

	logic                               div_ready, div_valid;
	logic [atan2pa_pkg::RATIO_BITS-1:0] div_z;
	atan2pa_pkg::side_t                 div_side;

	logic               poly_ready, poly_valid;
	logic signed [31:0] poly_th;
	atan2pa_pkg::side_t poly_side;

	logic fold_ready;

	// The negation of the most negative code wraps to its true magnitude.
	always_comb begin
		ax  = sample.x_coord[W-1] ? W'(-sample.x_coord) : W'(sample.x_coord);
		ay  = sample.y_coord[W-1] ? W'(-sample.y_coord) : W'(sample.y_coord);
		inv = ay > ax;
	end

	assign en_s1        = !vld_s1 || div_ready;
	assign sample_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mn_s1          <= inv ? ax : ay;
			mx_s1          <= inv ? ay : ax;
			side_s1.zero   <= (ax == '0) && (ay == '0);
			side_s1.invert <= inv;
			side_s1.x_neg  <= sample.x_coord[W-1];
			side_s1.y_neg  <= sample.y_coord[W-1];
		end
	end

	atan2pa_ratio_div #(
		.STEP_BITS(DIV_STEP_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (vld_s1),
		.up_ready (div_ready),
		.mn       (mn_s1),
		.mx       (mx_s1),
		.up_side  (side_s1),
		.dn_valid (div_valid),
		.dn_ready (poly_ready),
		.z        (div_z),
		.dn_side  (div_side)
	);

	atan2pa_poly u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (div_valid),
		.up_ready (poly_ready),
		.z        (div_z),
		.up_side  (div_side),
		.dn_valid (poly_valid),
		.dn_ready (fold_ready),
		.th       (poly_th),
		.dn_side  (poly_side)
	);

	atan2pa_fold u_fold (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (poly_valid),
		.up_ready (fold_ready),
		.th       (poly_th),
		.up_side  (poly_side),
		.dn_valid (result_valid),
		.dn_ready (!result_stall),
		.result   (result)
	);

	`ATAN2PA_ASSERT_IMPL(a_stall_means_full, sample_stall, vld_s1 && result_valid && result_stall)

endmodule
